// ----- hw/rtl/afr_pkg.sv -----
// afr_pkg: shared types and constants for the api frame receiver
`timescale 1ns / 1ps
`default_nettype none

package afr_pkg;

    // framing bytes
    localparam logic [7:0] DELIM        = 8'h7E;
    localparam logic [7:0] ESCAPE       = 8'h7D;
    localparam logic [7:0] ESC_XOR      = 8'h20;
    localparam logic [7:0] TYPE_RECEIVE = 8'h90;
    localparam logic [7:0] TYPE_MODEM   = 8'h8A;
    localparam logic [7:0] CHECK_BASE   = 8'hFF;

    // result status codes
    localparam logic [2:0] ST_RX_OK      = 3'd0;
    localparam logic [2:0] ST_MODEM_OK   = 3'd1;
    localparam logic [2:0] ST_CHECK_ERR  = 3'd2;
    localparam logic [2:0] ST_UNSUPPORT  = 3'd3;
    localparam logic [2:0] ST_TOO_LONG   = 3'd4;

    // frame data positions of the receive packet fields
    localparam int ADDR_FIRST_POS = 1;
    localparam int SRC_HI_POS     = 9;
    localparam int SRC_LO_POS     = 10;
    localparam int OPT_POS        = 11;
    localparam int PAY_FIRST_POS  = 12;

    // parser phase, one-hot
    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_LEN_HI = 5'b00010,
        PH_LEN_LO = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_CHECK  = 5'b10000
    } afr_phase_t;

    // one reported frame
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  frame_type;
        logic [63:0] dest_address;
        logic [15:0] source_address;
        logic [7:0]  option_byte;
        logic [63:0] payload;
        logic [7:0]  checksum_value;
    } afr_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/afr_parser.sv -----
// afr_parser: per-byte unescape, frame state and field capture
`timescale 1ns / 1ps
`default_nettype none

module afr_parser
    import afr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 24,
    parameter int PAYLOAD_BYTES   = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_fire,
    input  wire logic [7:0]  rx_byte,
    output logic             res_valid,
    output afr_result_t      res
);

    localparam int LEN_W = $clog2(MAX_FRAME_BYTES);
    localparam int PAY_W = 8 * PAYLOAD_BYTES;
    localparam logic [15:0] LEN_LIMIT = 16'(MAX_FRAME_BYTES - 4);

    // control state
    afr_phase_t       phase_reg, phase_next;
    logic             esc_reg, esc_next;

    // frame context
    logic [4:0]       idx_reg, idx_next;
    logic [7:0]       len_hi_reg, len_hi_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic             too_long_reg, too_long_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       type_reg, type_next;
    logic [63:0]      addr_reg, addr_next;
    logic [15:0]      src_reg, src_next;
    logic [7:0]       opt_reg, opt_next;
    logic [PAY_W-1:0] pay_reg, pay_next;

    logic [7:0]       data_byte;
    logic [15:0]      full_len;
    logic [7:0]       chk;
    logic [63:0]      pay_ext;

    assign data_byte = esc_reg ? (rx_byte ^ ESC_XOR) : rx_byte;
    assign full_len  = {len_hi_reg, data_byte};
    assign chk       = CHECK_BASE - sum_reg;
    assign pay_ext   = 64'(pay_reg) << (64 - PAY_W);

    // next state and result
    always_comb
    begin
        phase_next    = phase_reg;
        esc_next      = esc_reg;
        idx_next      = idx_reg;
        len_hi_next   = len_hi_reg;
        count_next    = count_reg;
        too_long_next = too_long_reg;
        sum_next      = sum_reg;
        type_next     = type_reg;
        addr_next     = addr_reg;
        src_next      = src_reg;
        opt_next      = opt_reg;
        pay_next      = pay_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (in_fire)
        begin
            priority if ((phase_reg == PH_HUNT && rx_byte == DELIM)
                         || (phase_reg != PH_HUNT && !esc_reg && rx_byte == DELIM))
            begin
                // an unescaped delimiter restarts the frame from any phase
                phase_next    = PH_LEN_HI;
                esc_next      = 1'b0;
                idx_next      = '0;
                len_hi_next   = '0;
                count_next    = '0;
                too_long_next = 1'b0;
                sum_next      = '0;
                type_next     = '0;
                addr_next     = '0;
                src_next      = '0;
                opt_next      = '0;
                pay_next      = '0;
            end
            else if (phase_reg == PH_HUNT)
            begin
                // other bytes ignored while hunting
            end
            else if (!esc_reg && rx_byte == ESCAPE)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                esc_next = 1'b0;
                unique case (phase_reg)
                    PH_LEN_HI:
                    begin
                        len_hi_next = data_byte;
                        phase_next  = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        if (full_len == 16'd0)
                        begin
                            res_valid       = 1'b1;
                            res.status      = ST_UNSUPPORT;
                            phase_next      = PH_HUNT;
                        end
                        else
                        begin
                            count_next    = LEN_W'(full_len);
                            too_long_next = full_len > LEN_LIMIT;
                            idx_next      = '0;
                            phase_next    = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        sum_next = sum_reg + data_byte;
                        if (idx_reg == 5'd0)
                        begin
                            type_next = data_byte;
                        end
                        else if (type_reg == TYPE_RECEIVE)
                        begin
                            // receive packet field capture by position
                            for (int i = 0; i < 8; i++)
                            begin
                                if (idx_reg == 5'(ADDR_FIRST_POS + i))
                                begin
                                    addr_next[63-8*i -: 8] = data_byte;
                                end
                            end
                            if (idx_reg == 5'(SRC_HI_POS))
                            begin
                                src_next[15:8] = data_byte;
                            end
                            if (idx_reg == 5'(SRC_LO_POS))
                            begin
                                src_next[7:0] = data_byte;
                            end
                            if (idx_reg == 5'(OPT_POS))
                            begin
                                opt_next = data_byte;
                            end
                            for (int i = 0; i < PAYLOAD_BYTES; i++)
                            begin
                                if (idx_reg == 5'(PAY_FIRST_POS + i))
                                begin
                                    pay_next[PAY_W-1-8*i -: 8] = data_byte;
                                end
                            end
                        end
                        else if (type_reg == TYPE_MODEM && idx_reg == 5'(ADDR_FIRST_POS))
                        begin
                            opt_next = data_byte;
                        end

                        priority if (idx_reg == 5'd0 && data_byte != TYPE_RECEIVE
                                     && data_byte != TYPE_MODEM)
                        begin
                            res_valid      = 1'b1;
                            res.status     = ST_UNSUPPORT;
                            res.frame_type = data_byte;
                            phase_next     = PH_HUNT;
                        end
                        else if (idx_reg == 5'd0 && too_long_reg)
                        begin
                            res_valid      = 1'b1;
                            res.status     = ST_TOO_LONG;
                            res.frame_type = data_byte;
                            phase_next     = PH_HUNT;
                        end
                        else
                        begin
                            if (idx_reg != 5'd31)
                            begin
                                idx_next = idx_reg + 5'd1;
                            end
                            count_next = count_reg - LEN_W'(1);
                            if (count_reg == LEN_W'(1))
                            begin
                                phase_next = PH_CHECK;
                            end
                        end
                    end
                    PH_CHECK:
                    begin
                        res_valid          = 1'b1;
                        res.frame_type     = type_reg;
                        res.checksum_value = chk;
                        phase_next         = PH_HUNT;
                        priority if (data_byte != chk)
                        begin
                            res.status = ST_CHECK_ERR;
                        end
                        else if (type_reg == TYPE_RECEIVE)
                        begin
                            res.status         = ST_RX_OK;
                            res.dest_address   = addr_reg;
                            res.source_address = src_reg;
                            res.option_byte    = opt_reg;
                            res.payload        = pay_ext;
                        end
                        else
                        begin
                            res.status      = ST_MODEM_OK;
                            res.option_byte = opt_reg;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            esc_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
        end
    end

    // frame context, cleared by each delimiter
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        len_hi_reg   <= len_hi_next;
        count_reg    <= count_next;
        too_long_reg <= too_long_next;
        sum_reg      <= sum_next;
        type_reg     <= type_next;
        addr_reg     <= addr_next;
        src_reg      <= src_next;
        opt_reg      <= opt_next;
        pay_reg      <= pay_next;
    end

    // no escape is pending while hunting
    a_esc_not_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> phase_reg != PH_HUNT)
        else $error("escape pending while hunting");

    // a report always returns to the hunt with no escape pending
    a_report_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (phase_reg == PH_HUNT && !esc_reg))
        else $error("parser not hunting after a report");

    // results only come from accepted items
    a_res_fire: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> in_fire)
        else $error("result without accepted item");

endmodule

`default_nettype wire

// ----- hw/rtl/afr_out_buf.sv -----
// afr_out_buf: output register with skid entry for reported frames
`timescale 1ns / 1ps
`default_nettype none

module afr_out_buf
    import afr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire afr_result_t push_data,
    output logic             full,
    output logic             out_valid,
    input  wire logic        out_stall,
    output afr_result_t      out_data
);

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    afr_result_t out_reg, out_next;
    afr_result_t skid_reg, skid_next;
    logic        pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // two-entry ordering: skid drains into output first
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        priority if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push && out_valid_reg && !pop)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
        else if (push)
        begin
            out_next       = push_data;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // skid entry never holds an item behind an empty output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output");

    // no push lands while both entries are occupied
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full output buffer");

    // a taken item with nothing behind it empties the output
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !skid_valid_reg && !push) |=> !out_valid_reg)
        else $error("output stayed valid after drain");

endmodule

`default_nettype wire

// ----- hw/rtl/api_frame_receiver_top.sv -----
// api_frame_receiver_top: escaped api frame parser, one raw byte per item
// output: a frame's report is registered in the output buffer, or its skid entry, when its last byte is accepted
// throughput: one byte per cycle while the output buffer is not full and in_stall is low
// a two-entry output buffer keeps taking bytes while one report waits
// reset: async active low, parser returns to hunting and the buffer empties
`timescale 1ns / 1ps
`default_nettype none

module api_frame_receiver_top
    import afr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 24,
    parameter int PAYLOAD_BYTES   = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [7:0]       frame_type,
    output logic [63:0]      dest_address,
    output logic [15:0]      source_address,
    output logic [7:0]       option_byte,
    output logic [63:0]      payload,
    output logic [7:0]       checksum_value
);

    logic        in_fire;
    logic        res_valid;
    afr_result_t res;
    afr_result_t out_data;
    logic        buf_full;

    // input handshake
    assign in_stall = buf_full;
    assign in_fire  = in_valid && !in_stall;

    afr_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .PAYLOAD_BYTES   (PAYLOAD_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    afr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // result fields
    assign status         = out_data.status;
    assign frame_type     = out_data.frame_type;
    assign dest_address   = out_data.dest_address;
    assign source_address = out_data.source_address;
    assign option_byte    = out_data.option_byte;
    assign payload        = out_data.payload;
    assign checksum_value = out_data.checksum_value;

endmodule

`default_nettype wire
